### sv/unsorted_array_priority_queue_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the unsorted array priority queue core.
// Shared forms for clocked checks that are gated off while reset is low.
// ---------------------------------------------------------------------------
`ifndef UNSORTED_ARRAY_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define UNSORTED_ARRAY_PRIORITY_QUEUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UAPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UAPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/uapq_pkg.sv
// ---------------------------------------------------------------------------
// Unsorted array priority queue package.
// Beat types, stored entry type and operation codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uapq_pkg;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;

    // One request beat.
    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        entry_id;
        logic signed [15:0] priority_req;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic               ok;
        logic [15:0]        out_id;
        logic signed [15:0] out_priority;
        logic [4:0]         count;
        logic               empty_res;
        logic               full_res;
    } t_out_beat;

    // One stored queue entry.
    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] pri;
    } t_entry;

endpackage

`default_nettype wire

### sv/unsorted_array_priority_queue_core.sv
// ---------------------------------------------------------------------------
// Unsorted array priority queue core.
// Bounded max-priority queue with insert, remove-highest and peek-highest.
// ---------------------------------------------------------------------------
// Entries live unsorted in a single-port-read memory of CAPACITY words. An
// insert, or any request that fails (insert when full, remove or peek when
// empty, unused mode), has its result beat ready in the cycle after it is
// accepted. A remove or peek scans the stored entries through the one memory
// read port with one signed comparator, one entry per cycle, and registers
// its result beat in a finish state after the scan. The queue accepts a new
// request beat only when it is idle and the previous result beat has been
// taken. Ties on priority go to the lowest storage index; a remove moves the
// last entry into the freed slot.
`timescale 1ns / 1ps
`default_nettype none

`include "unsorted_array_priority_queue_core_defines.svh"

module unsorted_array_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  uapq_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output uapq_pkg::t_out_beat  o_out_beat
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_scan_idx;
    logic                 r_dv;
    logic [IW-1:0]        r_dv_idx;
    logic [IW-1:0]        r_best_idx;
    uapq_pkg::t_entry     r_best;
    logic [1:0]           r_mode;
    logic                 r_out_valid;
    uapq_pkg::t_out_beat  r_out;

    uapq_pkg::t_entry     r_mem [CAPACITY];
    uapq_pkg::t_entry     r_rd_data;

    logic                 w_in_acc;
    logic                 w_full;
    logic [CW-1:0]        w_count_m1;
    logic [IW-1:0]        w_rd_addr;
    logic                 w_mem_we;
    logic [IW-1:0]        w_mem_waddr;
    uapq_pkg::t_entry     w_mem_wdata;
    uapq_pkg::t_entry     w_in_entry;

    // Build a result beat from the outcome, the entry and the new count.
    function automatic uapq_pkg::t_out_beat f_result(
        input logic             ok,
        input uapq_pkg::t_entry ent,
        input logic [CW-1:0]    cnt
    );
        uapq_pkg::t_out_beat res;
        logic [CW+4:0]       ext;
        ext              = {5'd0, cnt};
        res.ok           = ok;
        res.out_id       = ent.id;
        res.out_priority = ent.pri;
        res.count        = ext[4:0];
        res.empty_res    = (cnt == '0);
        res.full_res     = (cnt == CAP_C);
        return res;
    endfunction

    // Handshake and simple status.
    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign w_full      = (r_count == CAP_C);
    assign w_count_m1  = r_count - 1'b1;
    assign w_in_entry  = '{id: i_in_beat.entry_id, pri: i_in_beat.priority_req};

    // The scan reads indexes 0 to count-1, then the last entry for the refill.
    assign w_rd_addr = (r_scan_idx == r_count) ? w_count_m1[IW-1:0] : r_scan_idx[IW-1:0];

    // Memory write: append on insert, refill the hole on remove.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_count[IW-1:0];
        w_mem_wdata = w_in_entry;
        if (r_state == ST_IDLE) begin
            w_mem_we = w_in_acc && (i_in_beat.mode == uapq_pkg::MODE_INSERT) && !w_full;
        end else if (r_state == ST_FINISH && r_mode == uapq_pkg::MODE_REMOVE) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_best_idx;
            w_mem_wdata = r_rd_data;
        end
    end

    // Entry memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Sequencer, scan comparator and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_mode <= i_in_beat.mode;
                        case (i_in_beat.mode)
                            uapq_pkg::MODE_INSERT: begin
                                r_out_valid <= 1'b1;
                                if (w_full) begin
                                    r_out <= f_result(1'b0, '0, r_count);
                                end else begin
                                    r_out   <= f_result(1'b1, '0, r_count + 1'b1);
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            uapq_pkg::MODE_REMOVE, uapq_pkg::MODE_PEEK: begin
                                if (r_count == '0) begin
                                    r_out       <= f_result(1'b0, '0, r_count);
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_scan_idx <= '0;
                                    r_dv       <= 1'b0;
                                    r_state    <= ST_SCAN;
                                end
                            end
                            default: begin
                                r_out       <= f_result(1'b0, '0, r_count);
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // Compare the entry read in the previous cycle.
                    if (r_dv && (r_dv_idx == '0 || r_rd_data.pri > r_best.pri)) begin
                        r_best     <= r_rd_data;
                        r_best_idx <= r_dv_idx;
                    end
                    // Issue the next read, or the read of the last entry.
                    if (r_scan_idx != r_count) begin
                        r_dv       <= 1'b1;
                        r_dv_idx   <= r_scan_idx[IW-1:0];
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end else begin
                        r_dv    <= 1'b0;
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                    if (r_mode == uapq_pkg::MODE_REMOVE) begin
                        r_out   <= f_result(1'b1, r_best, w_count_m1);
                        r_count <= w_count_m1;
                    end else begin
                        r_out <= f_result(1'b1, r_best, r_count);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer and the reported status.
    `UAPQ_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CAP_C, "entry count above capacity")
    `UAPQ_ASSERT_NEXT(a_insert_ok, (w_in_acc && i_in_beat.mode == uapq_pkg::MODE_INSERT && !w_full), (o_out_valid && o_out_beat.ok), "insert into non-full queue did not succeed")
    `UAPQ_ASSERT_SAME(a_full_flag, o_out_valid, o_out_beat.full_res == (r_count == CAP_C), "full flag disagrees with stored count")
    `UAPQ_ASSERT_SAME(a_busy_not_ready, r_state != ST_IDLE, !o_in_ready && !o_out_valid, "request taken or result shown during a scan")

endmodule

`default_nettype wire
